>>> rtl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// No dependencies; imported by mm4_cell and matrix4_multiply.
`timescale 1ns / 1ps

package mm4_pkg;

	// Width of the element position field on the result stream.
	localparam int POS_W = 4;

	// Control tag that travels down the cell chain with each right-matrix element.
	typedef struct packed {
		logic valid;  // a right-matrix element is present
		logic first;  // first term of a dot product (k = 0)
		logic last;   // last term of a dot product (k = DIM-1)
	} mm4_tag_t;

endpackage

>>> rtl/mm4_cell.sv
// One row cell of the multiplier chain: holds one row of the left matrix and
// accumulates the dot product for that row. Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_cell import mm4_pkg::*; #(
	parameter int DIM = 4,
	parameter int EW  = 32,
	parameter int KW  = 2,
	parameter int AW  = 66,
	parameter int ROW = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 wr_en,
	input  logic [KW-1:0]        wr_row,
	input  logic [KW-1:0]        wr_col,
	input  logic signed [EW-1:0] wr_data,
	input  mm4_tag_t             tag_in,
	input  logic [KW-1:0]        k_in,
	input  logic signed [EW-1:0] b_in,
	output mm4_tag_t             tag_out,
	output logic [KW-1:0]        k_out,
	output logic signed [EW-1:0] b_out,
	output logic                 done,
	output logic signed [AW-1:0] acc
);

	logic signed [EW-1:0]   a_q [DIM];
	logic signed [2*EW-1:0] prod_s1;
	mm4_tag_t               tag_s1;
	mm4_tag_t               tag_q;
	logic [KW-1:0]          k_q;
	logic signed [EW-1:0]   b_q;
	logic signed [AW-1:0]   prod_ext;
	logic signed [AW-1:0]   acc_q;
	logic                   done_q;

	// Row storage of the left matrix, written while the operands are loaded.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_row == KW'(ROW))) begin
			a_q[wr_col] <= wr_data;
		end
	end

	// Hand the right-matrix element and its tag on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q  <= '0;
			tag_s1 <= '0;
			done_q <= 1'b0;
		end else if (en) begin
			tag_q  <= tag_in;
			tag_s1 <= tag_in;
			done_q <= tag_s1.valid && tag_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_q <= k_in;
			b_q <= b_in;
		end
	end

	// Multiply stage: row element times the passing column element.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a_q[k_in] * b_in;
		end
	end

	assign prod_ext = {{(AW-2*EW){prod_s1[2*EW-1]}}, prod_s1};

	// Accumulate stage: restart on the first term of each dot product.
	always_ff @(posedge clk) begin
		if (en && tag_s1.valid) begin
			if (tag_s1.first) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	assign tag_out = tag_q;
	assign k_out   = k_q;
	assign b_out   = b_q;
	assign done    = done_q;
	assign acc     = acc_q;

endmodule

>>> rtl/matrix4_multiply.sv
// Fixed-point DIM x DIM matrix multiplier, C = A * B, column-major streams.
// Throughput: DIM*DIM load transactions, then DIM*DIM results one per cycle
// while the output does not stall; the row-cell chain issues one column
// element per cycle while the output register can move.
// Reset clears the load position, sequencer and all valid flags; the matrix stores are not cleared.
`timescale 1ns / 1ps

module matrix4_multiply import mm4_pkg::*; #(
	parameter int DIM        = 4,
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// s_tdata fields from bit 0: left_element, right_element, zero padding
	input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0]       s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// m_tdata fields from bit 0: product_element, element_position, zero padding
	output logic [((ELEM_WIDTH+POS_W+7)/8)*8-1:0]   m_tdata,
	// m_tuser fields from bit 0: saturated
	output logic                                   m_tuser,
	output logic                                   m_tlast
);

	localparam int EW    = ELEM_WIDTH;
	localparam int KW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CELLS = DIM * DIM;
	localparam int PCW   = $clog2(CELLS);
	localparam int AW    = 2 * EW + $clog2(DIM);
	localparam int OW    = ((EW+POS_W+7)/8)*8;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]           state_q;
	logic                 en;
	logic                 in_acc;
	logic [KW-1:0]        load_row_q;
	logic [KW-1:0]        load_col_q;
	logic signed [EW-1:0] left_in;
	logic signed [EW-1:0] right_in;
	logic signed [EW-1:0] b_q [DIM][DIM];
	logic [KW-1:0]        seq_k_q;
	logic [KW-1:0]        seq_c_q;
	logic                 issue_last;

	mm4_tag_t             tag_w  [DIM];
	logic [KW-1:0]        k_w    [DIM];
	logic signed [EW-1:0] b_w    [DIM];
	logic                 done_w [DIM];
	logic signed [AW-1:0] acc_w  [DIM];

	logic                 any_done;
	logic signed [AW-1:0] sel_acc;
	logic signed [AW-1:0] shifted;
	logic                 fits;
	logic                 sat;
	logic signed [EW-1:0] clipped;
	logic [PCW-1:0]       res_cnt_q;
	logic                 res_last;
	logic [PCW+POS_W-1:0] pos_ext;

	logic                 m_tvalid_q;
	logic signed [EW-1:0] prod_q;
	logic [POS_W-1:0]     pos_q;
	logic                 sat_q;
	logic                 last_q;

	// The whole chain advances only when the output register can move.
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign left_in  = s_tdata[EW-1:0];
	assign right_in = s_tdata[2*EW-1:EW];

	assign issue_last = (seq_k_q == KW'(DIM-1)) && (seq_c_q == KW'(DIM-1));
	assign res_last   = (res_cnt_q == PCW'(CELLS-1));

	// Load position and product sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_row_q <= '0;
			load_col_q <= '0;
			seq_k_q    <= '0;
			seq_c_q    <= '0;
			res_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_row_q == KW'(DIM-1)) begin
							load_row_q <= '0;
							if (load_col_q == KW'(DIM-1)) begin
								load_col_q <= '0;
								state_q    <= ST_RUN;
							end else begin
								load_col_q <= load_col_q + 1'b1;
							end
						end else begin
							load_row_q <= load_row_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (en) begin
						if (seq_k_q == KW'(DIM-1)) begin
							seq_k_q <= '0;
							seq_c_q <= (seq_c_q == KW'(DIM-1)) ? '0 : seq_c_q + 1'b1;
						end else begin
							seq_k_q <= seq_k_q + 1'b1;
						end
						if (issue_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (en && any_done && res_last) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			if (en && any_done) begin
				res_cnt_q <= res_last ? '0 : res_cnt_q + 1'b1;
			end
		end
	end

	// Right-matrix store, addressed by row and column.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			b_q[load_row_q][load_col_q] <= right_in;
		end
	end

	// Issue register feeding the first cell: one right-matrix element per cycle while the chain is enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_w[0] <= '0;
		end else if (en) begin
			tag_w[0].valid <= (state_q == ST_RUN);
			tag_w[0].first <= (seq_k_q == '0);
			tag_w[0].last  <= (seq_k_q == KW'(DIM-1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_w[0] <= seq_k_q;
			b_w[0] <= b_q[seq_k_q][seq_c_q];
		end
	end

	// Chain of row cells; each hands the column element to the next row.
	for (genvar r = 0; r < DIM; r++) begin : g_cell
		if (r < DIM - 1) begin : g_mid
			mm4_cell #(
				.DIM (DIM),
				.EW  (EW),
				.KW  (KW),
				.AW  (AW),
				.ROW (r)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.wr_en   (in_acc),
				.wr_row  (load_row_q),
				.wr_col  (load_col_q),
				.wr_data (left_in),
				.tag_in  (tag_w[r]),
				.k_in    (k_w[r]),
				.b_in    (b_w[r]),
				.tag_out (tag_w[r+1]),
				.k_out   (k_w[r+1]),
				.b_out   (b_w[r+1]),
				.done    (done_w[r]),
				.acc     (acc_w[r])
			);
		end else begin : g_end
			mm4_cell #(
				.DIM (DIM),
				.EW  (EW),
				.KW  (KW),
				.AW  (AW),
				.ROW (r)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.wr_en   (in_acc),
				.wr_row  (load_row_q),
				.wr_col  (load_col_q),
				.wr_data (left_in),
				.tag_in  (tag_w[r]),
				.k_in    (k_w[r]),
				.b_in    (b_w[r]),
				.tag_out (),
				.k_out   (),
				.b_out   (),
				.done    (done_w[r]),
				.acc     (acc_w[r])
			);
		end
	end

	// At most one cell finishes per cycle, and they finish in index order.
	always_comb begin
		any_done = 1'b0;
		sel_acc  = '0;
		for (int r = 0; r < DIM; r++) begin
			any_done = any_done | done_w[r];
			sel_acc  = sel_acc | (done_w[r] ? acc_w[r] : '0);
		end
	end

	// Floor shift of the exact sum, then clip to the element range.
	assign shifted = sel_acc >>> FRAC_BITS;
	assign fits    = (&shifted[AW-1:EW-1]) || !(|shifted[AW-1:EW-1]);
	assign sat     = !fits;

	always_comb begin
		if (fits) begin
			clipped = shifted[EW-1:0];
		end else if (sel_acc[AW-1]) begin
			clipped = {1'b1, {(EW-1){1'b0}}};
		end else begin
			clipped = {1'b0, {(EW-1){1'b1}}};
		end
	end

	assign pos_ext = {{POS_W{1'b0}}, res_cnt_q};

	// Output register: holds a result until the downstream transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= any_done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= clipped;
			pos_q  <= pos_ext[POS_W-1:0];
			sat_q  <= sat;
			last_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OW-EW-POS_W){1'b0}}, pos_q, prod_q};
	assign m_tuser  = sat_q;
	assign m_tlast  = last_q;

endmodule
